// File: sv/ramu_pkg.sv
`timescale 1ns / 1ps
package ramu_pkg;

	// data width of every operand and intermediate kept after overflow checks
	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;
	localparam int IN_TDATA_W = 136;
	localparam int OUT_TDATA_W = 72;

	// datapath commands
	localparam logic [3:0] CMD_NONE    = 4'd0;
	localparam logic [3:0] CMD_LOAD    = 4'd1;
	localparam logic [3:0] CMD_GCD_DEN = 4'd2;
	localparam logic [3:0] CMD_DIV_FA  = 4'd3;
	localparam logic [3:0] CMD_DIV_FB  = 4'd4;
	localparam logic [3:0] CMD_MUL_XA  = 4'd5;
	localparam logic [3:0] CMD_MUL_XB  = 4'd6;
	localparam logic [3:0] CMD_MUL_DEN = 4'd7;
	localparam logic [3:0] CMD_COMB    = 4'd8;
	localparam logic [3:0] CMD_GCD_RES = 4'd9;
	localparam logic [3:0] CMD_DIV_NUM = 4'd10;
	localparam logic [3:0] CMD_DIV_DEN = 4'd11;
	localparam logic [3:0] CMD_OUT     = 4'd12;

	typedef struct packed {
		logic [3:0] op;
	} cmd_t;

	typedef struct packed {
		logic ovf;
		logic mul;
		logic gcd_done;
		logic div_done;
	} status_t;

endpackage

// File: sv/ramu_gcd.sv
`timescale 1ns / 1ps
module ramu_gcd (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ramu_pkg::DATA_W-1:0]   a,
	input  logic [ramu_pkg::DATA_W-1:0]   b,
	output logic                          done,
	output logic [ramu_pkg::DATA_W-1:0]   result
);

	localparam logic [1:0] PH_DONE   = 2'd0;
	localparam logic [1:0] PH_TWOS   = 2'd1;
	localparam logic [1:0] PH_REDUCE = 2'd2;

	logic [1:0]                    phase_q;
	logic [ramu_pkg::DATA_W-1:0]   p_q;
	logic [ramu_pkg::DATA_W-1:0]   q_q;
	logic [$clog2(ramu_pkg::DATA_W)-1:0] sh_q;

	// one binary gcd step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
		end else if (start) begin
			if (a == '0 || b == '0) begin
				phase_q <= PH_DONE;
			end else begin
				phase_q <= PH_TWOS;
			end
		end else begin
			case (phase_q)
				PH_TWOS: begin
					if (p_q[0] || q_q[0]) begin
						phase_q <= PH_REDUCE;
					end
				end
				PH_REDUCE: begin
					if (p_q[0] && q_q[0] && p_q == q_q) begin
						phase_q <= PH_DONE;
					end
				end
				default: phase_q <= PH_DONE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= '0;
			if (a == '0) begin
				p_q <= b;
			end else begin
				p_q <= a;
			end
			q_q <= b;
		end else if (phase_q == PH_TWOS) begin
			if (!p_q[0] && !q_q[0]) begin
				p_q  <= p_q >> 1;
				q_q  <= q_q >> 1;
				sh_q <= sh_q + 1'b1;
			end
		end else if (phase_q == PH_REDUCE) begin
			if (!p_q[0]) begin
				p_q <= p_q >> 1;
			end else if (!q_q[0]) begin
				q_q <= q_q >> 1;
			end else if (p_q > q_q) begin
				p_q <= p_q - q_q;
			end else if (q_q > p_q) begin
				q_q <= q_q - p_q;
			end
		end
	end

	assign done   = (phase_q == PH_DONE);
	assign result = p_q << sh_q;

endmodule

// File: sv/ramu_div.sv
`timescale 1ns / 1ps
module ramu_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ramu_pkg::DATA_W-1:0]   dividend,
	input  logic [ramu_pkg::DATA_W-1:0]   divisor,
	output logic                          done,
	output logic [ramu_pkg::DATA_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(ramu_pkg::DATA_W + 1);

	logic                          busy_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [ramu_pkg::DATA_W-1:0]   rem_q;
	logic [ramu_pkg::DATA_W-1:0]   quo_q;
	logic [ramu_pkg::DATA_W-1:0]   div_q;
	logic [ramu_pkg::DATA_W:0]     shifted;
	logic [ramu_pkg::DATA_W:0]     trial;

	// restoring division, one quotient bit per cycle
	assign shifted = {rem_q, quo_q[ramu_pkg::DATA_W-1]};
	assign trial   = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(ramu_pkg::DATA_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!trial[ramu_pkg::DATA_W]) begin
				rem_q <= trial[ramu_pkg::DATA_W-1:0];
				quo_q <= {quo_q[ramu_pkg::DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[ramu_pkg::DATA_W-1:0];
				quo_q <= {quo_q[ramu_pkg::DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = !busy_q;
	assign quotient = quo_q;

endmodule

// File: sv/ramu_dpath.sv
`timescale 1ns / 1ps
module ramu_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ramu_pkg::cmd_t                      cmd,
	output ramu_pkg::status_t                   status,
	input  logic [ramu_pkg::IN_TDATA_W-1:0]     in_data,
	input  logic                                in_kind,
	output logic [ramu_pkg::OUT_TDATA_W-1:0]    out_data,
	output logic                                out_ovf
);

	localparam int W = ramu_pkg::DATA_W;

	logic [W-1:0]   na_q, da_q, nb_q, db_q;
	logic           sa_q, sb_q, mul_q, ovf_q, sign_q;
	logic [W-1:0]   fa_q, fb_q, num_q, rnum_q;
	logic [ramu_pkg::PROD_W-1:0] xa_q, xb_q, den_q;
	logic           res_neg_q, res_ovf_q;
	logic [W-1:0]   res_num_q, res_den_q;

	logic           gcd_start, div_start;
	logic [W-1:0]   gcd_a, gcd_b, gcd_res, div_n, quot;
	logic           gcd_done, div_done;
	logic [W-1:0]   mul_x, mul_y;
	logic [ramu_pkg::PROD_W-1:0] prod;
	logic [W:0]     sum;
	logic           big_hi;

	// operand selection for the shared units
	assign gcd_start = (cmd.op == ramu_pkg::CMD_GCD_DEN) || (cmd.op == ramu_pkg::CMD_GCD_RES);
	assign gcd_a     = (cmd.op == ramu_pkg::CMD_GCD_RES) ? num_q : da_q;
	assign gcd_b     = (cmd.op == ramu_pkg::CMD_GCD_RES) ? den_q[W-1:0] : db_q;

	always_comb begin
		div_start = 1'b1;
		case (cmd.op)
			ramu_pkg::CMD_DIV_FA:  div_n = db_q;
			ramu_pkg::CMD_DIV_FB:  div_n = da_q;
			ramu_pkg::CMD_DIV_NUM: div_n = num_q;
			ramu_pkg::CMD_DIV_DEN: div_n = den_q[W-1:0];
			default: begin
				div_n     = '0;
				div_start = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (cmd.op)
			ramu_pkg::CMD_MUL_XB: begin
				mul_x = nb_q;
				mul_y = fb_q;
			end
			ramu_pkg::CMD_MUL_DEN: begin
				mul_x = da_q;
				mul_y = mul_q ? db_q : fa_q;
			end
			default: begin
				mul_x = na_q;
				mul_y = mul_q ? nb_q : fa_q;
			end
		endcase
	end

	assign prod   = ramu_pkg::PROD_W'(mul_x) * ramu_pkg::PROD_W'(mul_y);
	assign sum    = {1'b0, xa_q[W-1:0]} + {1'b0, xb_q[W-1:0]};
	assign big_hi = (xa_q[ramu_pkg::PROD_W-1:W] != '0) || (den_q[ramu_pkg::PROD_W-1:W] != '0)
		|| (!mul_q && xb_q[ramu_pkg::PROD_W-1:W] != '0);

	ramu_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.a      (gcd_a),
		.b      (gcd_b),
		.done   (gcd_done),
		.result (gcd_res)
	);

	ramu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (gcd_res),
		.done     (div_done),
		.quotient (quot)
	);

	// working registers, written per command
	always_ff @(posedge clk) begin
		case (cmd.op)
			ramu_pkg::CMD_LOAD: begin
				sa_q  <= in_data[0];
				na_q  <= in_data[32:1];
				da_q  <= in_data[64:33];
				sb_q  <= in_data[65];
				nb_q  <= in_data[97:66];
				db_q  <= in_data[129:98];
				mul_q <= in_kind;
				ovf_q <= (in_data[64:33] == '0) || (in_data[129:98] == '0);
			end
			ramu_pkg::CMD_DIV_FB:  fa_q <= quot;
			ramu_pkg::CMD_MUL_XA: begin
				fb_q <= quot;
				xa_q <= prod;
			end
			ramu_pkg::CMD_MUL_XB:  xb_q <= prod;
			ramu_pkg::CMD_MUL_DEN: den_q <= prod;
			ramu_pkg::CMD_COMB: begin
				if (mul_q) begin
					sign_q <= sa_q ^ sb_q;
					num_q  <= xa_q[W-1:0];
					ovf_q  <= ovf_q | big_hi;
				end else if (sa_q == sb_q) begin
					sign_q <= sa_q;
					num_q  <= sum[W-1:0];
					ovf_q  <= ovf_q | big_hi | sum[W];
				end else if (xa_q[W-1:0] > xb_q[W-1:0]) begin
					sign_q <= sa_q;
					num_q  <= xa_q[W-1:0] - xb_q[W-1:0];
					ovf_q  <= ovf_q | big_hi;
				end else begin
					sign_q <= sb_q;
					num_q  <= xb_q[W-1:0] - xa_q[W-1:0];
					ovf_q  <= ovf_q | big_hi;
				end
			end
			ramu_pkg::CMD_DIV_DEN: rnum_q <= quot;
			ramu_pkg::CMD_OUT: begin
				res_ovf_q <= ovf_q;
				res_neg_q <= ovf_q ? 1'b0 : sign_q;
				res_num_q <= ovf_q ? '0 : rnum_q;
				res_den_q <= ovf_q ? W'(1) : quot;
			end
			default: begin
			end
		endcase
	end

	assign status.ovf      = ovf_q;
	assign status.mul      = mul_q;
	assign status.gcd_done = gcd_done;
	assign status.div_done = div_done;

	assign out_data = {7'b0, res_den_q, res_num_q, res_neg_q};
	assign out_ovf  = res_ovf_q;

endmodule

// File: sv/ramu_ctrl.sv
`timescale 1ns / 1ps
module ramu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ramu_pkg::cmd_t    cmd,
	input  ramu_pkg::status_t status
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_G1   = 5'd1;
	localparam logic [4:0] S_G1W  = 5'd2;
	localparam logic [4:0] S_DA   = 5'd3;
	localparam logic [4:0] S_DAW  = 5'd4;
	localparam logic [4:0] S_DB   = 5'd5;
	localparam logic [4:0] S_DBW  = 5'd6;
	localparam logic [4:0] S_MXA  = 5'd7;
	localparam logic [4:0] S_MXB  = 5'd8;
	localparam logic [4:0] S_MDEN = 5'd9;
	localparam logic [4:0] S_COMB = 5'd10;
	localparam logic [4:0] S_G2   = 5'd11;
	localparam logic [4:0] S_G2W  = 5'd12;
	localparam logic [4:0] S_DN   = 5'd13;
	localparam logic [4:0] S_DNW  = 5'd14;
	localparam logic [4:0] S_DD   = 5'd15;
	localparam logic [4:0] S_DDW  = 5'd16;
	localparam logic [4:0] S_FIN  = 5'd17;

	logic [4:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_load;

	// next state and command
	always_comb begin
		state_d = state_q;
		cmd.op  = ramu_pkg::CMD_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = ramu_pkg::CMD_LOAD;
					state_d = S_G1;
				end
			end
			S_G1: begin
				if (status.ovf) begin
					state_d = S_FIN;
				end else if (status.mul) begin
					state_d = S_MXA;
				end else begin
					cmd.op  = ramu_pkg::CMD_GCD_DEN;
					state_d = S_G1W;
				end
			end
			S_G1W:  if (status.gcd_done) state_d = S_DA;
			S_DA: begin
				cmd.op  = ramu_pkg::CMD_DIV_FA;
				state_d = S_DAW;
			end
			S_DAW:  if (status.div_done) state_d = S_DB;
			S_DB: begin
				cmd.op  = ramu_pkg::CMD_DIV_FB;
				state_d = S_DBW;
			end
			S_DBW:  if (status.div_done) state_d = S_MXA;
			S_MXA: begin
				cmd.op  = ramu_pkg::CMD_MUL_XA;
				state_d = status.mul ? S_MDEN : S_MXB;
			end
			S_MXB: begin
				cmd.op  = ramu_pkg::CMD_MUL_XB;
				state_d = S_MDEN;
			end
			S_MDEN: begin
				cmd.op  = ramu_pkg::CMD_MUL_DEN;
				state_d = S_COMB;
			end
			S_COMB: begin
				cmd.op  = ramu_pkg::CMD_COMB;
				state_d = S_G2;
			end
			S_G2: begin
				if (status.ovf) begin
					state_d = S_FIN;
				end else begin
					cmd.op  = ramu_pkg::CMD_GCD_RES;
					state_d = S_G2W;
				end
			end
			S_G2W:  if (status.gcd_done) state_d = S_DN;
			S_DN: begin
				cmd.op  = ramu_pkg::CMD_DIV_NUM;
				state_d = S_DNW;
			end
			S_DNW:  if (status.div_done) state_d = S_DD;
			S_DD: begin
				cmd.op  = ramu_pkg::CMD_DIV_DEN;
				state_d = S_DDW;
			end
			S_DDW:  if (status.div_done) state_d = S_FIN;
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = ramu_pkg::CMD_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_load = (cmd.op == ramu_pkg::CMD_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: sv/rational_add_multiply_unit.sv
`timescale 1ns / 1ps
// sequence: an add runs two binary gcd runs and four divisions, a multiply runs one
// binary gcd run and two divisions
// throughput: one beat at a time; the next beat is taken once the result is in the
// output register, which holds it while the next beat is worked on
// the shared gcd unit and the bit-serial divider set the time a beat takes
// reset: arst_n clears the controller and the output valid at once
module rational_add_multiply_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// a_negative, a_numerator, a_denominator, b_negative, b_numerator, b_denominator
	input  logic [ramu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// req_type
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// result_negative, result_numerator, result_denominator
	output logic [ramu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// overflow
	output logic                                m_axis_tuser
);

	ramu_pkg::cmd_t    cmd;
	ramu_pkg::status_t status;

	ramu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.status    (status)
	);

	ramu_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_data  (s_axis_tdata),
		.in_kind  (s_axis_tuser),
		.out_data (m_axis_tdata),
		.out_ovf  (m_axis_tuser)
	);

endmodule

// File: sv/ramu_checker.sv
`timescale 1ns / 1ps
module ramu_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [ramu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input logic                                m_axis_tuser
);

	// an overflowed result is always 0/1 with a clear sign
	a_ovf_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tdata[32:0] == '0 && m_axis_tdata[64:33] == 32'd1)
		else $error("overflow result not fixed at 0/1");

	// a valid result never has a zero denominator
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[64:33] != '0)
		else $error("zero denominator on output");

	// an accepted beat moves the controller out of idle, so ready drops after it
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken on back-to-back cycles");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output changed");

endmodule

bind rational_add_multiply_unit ramu_checker u_ramu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
